### rtl/core/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// tdpc_pkg
// Types, constants and helper functions shared by the two-dimensional parity
// codec modules.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  // Results that one check-mode block may emit at most.
  localparam int MaxOut = 8;

  // Largest flip count that the output field can show.
  localparam int FlipsMax = 127;

  // Depth of the command queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_STORE,
    OP_ENCODE,
    OP_BURST
  } cmd_op_e;

  // One command from the front to the back.
  //   OP_STORE:  data is the received byte, flag is its row-parity failure,
  //              first marks the first row of a block.
  //   OP_ENCODE: data is the byte, flag asks for the column byte in aux.
  //   OP_BURST:  data is the failing-column mask, flips is the flip count.
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
    logic [7:0] aux;
    logic       flag;
    logic       first;
    logic [6:0] flips;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTE,
    ST_COLUMN,
    ST_ROW
  } back_state_e;

  // One when the byte holds an odd number of ones.
  function automatic logic odd_ones(input logic [7:0] v);
    logic p;
    p = 1'b0;
    for (int b = 0; b < 8; b++) begin
      p = p ^ v[b];
    end
    return p;
  endfunction

  // Number of ones in a byte.
  function automatic logic [3:0] ones(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'd0, v[b]};
    end
    return n;
  endfunction

endpackage

### rtl/core/tdpc_queue.sv
// ----------------------------------------------------------------------------
// tdpc_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module tdpc_queue
  import tdpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t             slot_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] count_q, count_d;

  function automatic logic [QPtrW-1:0] bump(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? bump(wptr_q) : wptr_q;
    rptr_d  = pop_i ? bump(rptr_q) : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command popped from an empty queue");
`endif

endmodule

### rtl/core/tdpc_front.sv
// ----------------------------------------------------------------------------
// tdpc_front
// Accepts input items, keeps the per-block row count, column accumulator and
// failing-row count, and turns each item into a command for the back.
// ----------------------------------------------------------------------------
module tdpc_front
  import tdpc_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       row_parity_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int RCW  = $clog2(ROWS + 1);
  localparam int PW   = RCW + 4;
  localparam int PwX  = (PW > 7) ? PW : 7;

  logic           mode_q;
  logic [RCW-1:0] row_count_q, row_count_d;
  logic [RCW-1:0] bad_cnt_q, bad_cnt_d;
  logic [7:0]     acc_q, acc_d;

  logic           take;
  logic [7:0]     acc_next;
  logic           row_bad;
  logic [PW-1:0]  prod;
  logic [PwX-1:0] prod_x;
  logic [6:0]     flips;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && !full_i;
  assign acc_next   = acc_q ^ byte_value_i;
  assign row_bad    = odd_ones(byte_value_i) ^ row_parity_i;

  // Flip count: failing rows times failing columns, saturated.
  assign prod   = PW'(bad_cnt_q) * PW'(ones(acc_next));
  assign prod_x = PwX'(prod);
  assign flips  = (prod_x > PwX'(FlipsMax)) ? 7'(FlipsMax) : prod_x[6:0];

  always_comb begin
    row_count_d = row_count_q;
    bad_cnt_d   = bad_cnt_q;
    acc_d       = acc_q;
    push_o      = 1'b0;
    cmd_o       = '{op: OP_ENCODE, data: byte_value_i, aux: acc_next,
                    flag: 1'b0, first: 1'b0, flips: flips};
    if (cfg_we_i) begin
      row_count_d = '0;
      bad_cnt_d   = '0;
      acc_d       = '0;
    end else if (take) begin
      push_o = 1'b1;
      if (!mode_q) begin
        if (row_count_q >= RCW'(ROWS - 1)) begin
          cmd_o.flag  = 1'b1;
          row_count_d = '0;
          acc_d       = '0;
        end else begin
          row_count_d = row_count_q + RCW'(1);
          acc_d       = acc_next;
        end
      end else if (row_count_q < RCW'(ROWS)) begin
        cmd_o.op    = OP_STORE;
        cmd_o.flag  = row_bad;
        cmd_o.first = (row_count_q == '0);
        row_count_d = row_count_q + RCW'(1);
        bad_cnt_d   = bad_cnt_q + RCW'(row_bad);
        acc_d       = acc_next;
      end else begin
        cmd_o.op    = OP_BURST;
        cmd_o.data  = acc_next;
        row_count_d = '0;
        bad_cnt_d   = '0;
        acc_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      row_count_q <= '0;
      bad_cnt_q   <= '0;
      acc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      row_count_q <= row_count_d;
      bad_cnt_q   <= bad_cnt_d;
      acc_q       <= acc_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (row_count_q == '0 && acc_q == '0 && bad_cnt_q == '0))
    else $error("configuration write did not drop the partial block");
  a_bad_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_cnt_q <= row_count_q)
    else $error("failing-row count exceeds stored rows");
`endif

endmodule

### rtl/core/tdpc_back.sv
// ----------------------------------------------------------------------------
// tdpc_back
// Carries out queued commands: stores received rows, emits encoded bytes and
// column parity, and plays the corrected rows back after a check block.
// ----------------------------------------------------------------------------
module tdpc_back
  import tdpc_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_parity_o,
  output logic       is_column_parity_o,
  output logic [6:0] flips_made_o,
  output logic       last_o
);

  localparam int AW      = $clog2(ROWS);
  localparam int NOut    = (ROWS < MaxOut) ? ROWS : MaxOut;

  back_state_e   state_q, state_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic [AW-1:0] waddr, rd_addr;
  logic          wr_en;

  logic [8:0]    row_mem [ROWS];
  logic [8:0]    rd_q;

  logic [7:0]    hold_q, col_q;
  logic          with_col_q;
  logic [6:0]    flips_q;
  logic          load;

  logic [7:0]    byte_out;
  logic          row_last;

  assign waddr    = cmd_i.first ? '0 : wptr_q;
  assign row_last = (ridx_q == AW'(NOut - 1));

  always_comb begin
    state_d = state_q;
    wptr_d  = wptr_q;
    ridx_d  = ridx_q;
    rd_addr = ridx_q;
    pop_o   = 1'b0;
    wr_en   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr = '0;
        if (!empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_STORE: begin
              wr_en  = 1'b1;
              wptr_d = waddr + AW'(1);
            end
            OP_ENCODE: begin
              load    = 1'b1;
              state_d = ST_BYTE;
            end
            OP_BURST: begin
              load    = 1'b1;
              ridx_d  = '0;
              state_d = ST_ROW;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_BYTE: begin
        if (out_ready_i) begin
          state_d = with_col_q ? ST_COLUMN : ST_IDLE;
        end
      end
      ST_COLUMN: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_ROW: begin
        if (out_ready_i) begin
          if (row_last) begin
            state_d = ST_IDLE;
          end else begin
            ridx_d  = ridx_q + AW'(1);
            rd_addr = ridx_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wptr_q  <= '0;
      ridx_q  <= '0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      ridx_q  <= ridx_d;
    end
  end

  // Row store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[waddr] <= {cmd_i.flag, cmd_i.data};
    end
    rd_q <= row_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_q     <= cmd_i.data;
      col_q      <= cmd_i.aux;
      with_col_q <= cmd_i.flag;
      flips_q    <= cmd_i.flips;
    end
  end

  always_comb begin
    out_valid_o        = 1'b0;
    byte_out           = hold_q;
    is_column_parity_o = 1'b0;
    flips_made_o       = 7'd0;
    last_o             = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        out_valid_o = 1'b0;
      end
      ST_BYTE: begin
        out_valid_o = 1'b1;
      end
      ST_COLUMN: begin
        out_valid_o        = 1'b1;
        byte_out           = col_q;
        is_column_parity_o = 1'b1;
        last_o             = 1'b1;
      end
      ST_ROW: begin
        out_valid_o  = 1'b1;
        byte_out     = rd_q[7:0] ^ (rd_q[8] ? hold_q : 8'd0);
        flips_made_o = flips_q;
        last_o       = row_last;
      end
      default: begin
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign out_byte_o   = byte_out;
  assign out_parity_o = odd_ones(byte_out);

`ifndef NO_ASSERTIONS
  a_row_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW && !out_ready_i) |=> $stable(rd_q))
    else $error("stalled corrected row changed");
`endif

endmodule

### rtl/core/two_dimensional_parity_codec_top.sv
// ----------------------------------------------------------------------------
// two_dimensional_parity_codec_top
// Two-dimensional even-parity encoder and single-block corrector.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                                  Direction  Handshake
//   cfg      cfg_we_i, cfg_wdata_i                    in         write enable
//   in       byte_value_i, row_parity_i               in         valid/ready
//   out      out_byte_o, out_parity_o,                out        valid/ready
//            is_column_parity_o, flips_made_o, last_o
//
// The front accepts an item in any cycle in which the two-entry command queue
// has room, so a stalled output backs up only after two items are queued.
// Encode mode gives one result per item in the cycle after it reaches the back;
// the last byte of a block adds the column parity result once its byte result is taken.
// In check mode a data byte only writes the row store; the column byte starts
// a burst of min(ROWS, 8) corrected rows, one per cycle from the store's
// registered read port, so the burst and the stalls on out set the rate.
// Reset clears control state only; the row store needs no clearing pass, as
// every check block writes all of its rows before they are read.
//
module two_dimensional_parity_codec_top
  import tdpc_pkg::*;
#(
  parameter int ROWS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       row_parity_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_parity_o,
  output logic       is_column_parity_o,
  output logic [6:0] flips_made_o,
  output logic       last_o
);

  // Commands travel from front to back through the queue.
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // The front classifies each item and tracks per-block parity state.
  tdpc_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .row_parity_i (row_parity_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  tdpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  // The back owns the row store and drives the result channel.
  tdpc_back #(
    .ROWS (ROWS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (head_cmd),
    .empty_i            (empty),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .out_parity_o       (out_parity_o),
    .is_column_parity_o (is_column_parity_o),
    .flips_made_o       (flips_made_o),
    .last_o             (last_o)
  );

`ifndef NO_ASSERTIONS
  a_col_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_column_parity_o) |-> (last_o && flips_made_o == 7'd0))
    else $error("column parity result is not the final one of its block");
`endif

endmodule
